// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int OP_W      = 3;
    localparam int FIELD_W   = 32;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEG  = 3'd4;
    localparam logic [OP_W-1:0] OP_SQRT = 3'd5;
    localparam logic [OP_W-1:0] OP_NORM = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZDEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SQRT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

endpackage

// ===== sv/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_operation, s_a_num, s_a_den, s_b_num, s_b_den
// m_        out        m_valid, m_ready, m_res_num, m_res_den, m_status
//
// One transfer at a time: s_ready is high only while the sequencer is idle.
// A binary operation runs three shift-and-add multiplies, then a binary gcd, then
// restoring division of numerator and denominator by the gcd; square root adds a
// bitwise root of each part. All steps share one 2*WIDTH+1 bit adder, which sets
// the rate.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_valid.
// A result waiting on m_ready holds the sequencer in its final state.

module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rau_pkg::OP_W-1:0]      s_operation,
    input  logic signed [rau_pkg::FIELD_W-1:0] s_a_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] s_a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] s_b_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] s_b_den,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rau_pkg::NUM_W-1:0] m_res_num,
    output logic [rau_pkg::DEN_W-1:0]     m_res_den,
    output logic [rau_pkg::STATUS_W-1:0]  m_status
);

    localparam int DW = 2 * WIDTH;
    localparam int AW = DW + 1;
    localparam int CW = $clog2(DW + 1);
    localparam int SW = WIDTH + (WIDTH % 2);
    localparam int HW = SW / 2;
    localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_COMB  = 4'd2;
    localparam logic [3:0] S_COMB2 = 4'd3;
    localparam logic [3:0] S_GINIT = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_GSH   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_CHK   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    logic [rau_pkg::OP_W-1:0] op_reg, op_next;
    logic [WIDTH-1:0] an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    logic s1_reg, s1_next, s2_reg, s2_next, sd_reg, sd_next, nneg_reg, nneg_next;
    logic [DW-1:0] p_reg, p_next, u_reg, u_next, v_reg, v_next;
    logic [DW-1:0] mc_reg, mc_next, acc_reg, acc_next;
    logic [WIDTH-1:0] mp_reg, mp_next;
    logic [DW-1:0] num_reg, num_next, den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next, q_reg, q_next;
    logic [CW-1:0] k_reg, k_next, cnt_reg, cnt_next;
    logic [1:0] slot_reg, slot_next;
    logic sel_reg, sel_next, inexact_reg, inexact_next;
    logic [SW-1:0] src_reg, src_next;
    logic [HW-1:0] root_reg, root_next, rn_reg, rn_next;
    logic [rau_pkg::STATUS_W-1:0] st_reg, st_next;
    logic signed [rau_pkg::NUM_W-1:0] out_num_reg, out_num_next;
    logic [rau_pkg::DEN_W-1:0] out_den_reg, out_den_next;
    logic [rau_pkg::STATUS_W-1:0] out_st_reg, out_st_next;

    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_borrow;

    logic [WIDTH-1:0] an_raw, ad_raw, bn_raw, bd_raw;
    logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
    logic an_neg, ad_neg, bn_neg, bd_neg;

    logic [DW-1:0] acc_n, qn, tr, trial;
    logic [AW-1:0] dtmp;
    logic          qbit, sq_ok;
    logic [HW-1:0] rootn;
    logic [DW-1:0] sq_rem;
    logic [rau_pkg::NUM_W-1:0] mag32;

    rau_alu #(.AW(AW)) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res_num = out_num_reg;
    assign m_res_den = out_den_reg;
    assign m_status  = out_st_reg;

    always_comb begin
        an_raw = s_a_num[WIDTH-1:0];
        ad_raw = s_a_den[WIDTH-1:0];
        bn_raw = s_b_num[WIDTH-1:0];
        bd_raw = s_b_den[WIDTH-1:0];
        an_neg = an_raw[WIDTH-1];
        ad_neg = ad_raw[WIDTH-1];
        bn_neg = bn_raw[WIDTH-1];
        bd_neg = bd_raw[WIDTH-1];
        an_mag = an_neg ? ({WIDTH{1'b0}} - an_raw) : an_raw;
        ad_mag = ad_neg ? ({WIDTH{1'b0}} - ad_raw) : ad_raw;
        bn_mag = bn_neg ? ({WIDTH{1'b0}} - bn_raw) : bn_raw;
        bd_mag = bd_neg ? ({WIDTH{1'b0}} - bd_raw) : bd_raw;
    end

    always_comb begin
        dtmp  = {rem_reg, q_reg[DW-1]};
        tr    = {rem_reg[DW-3:0], src_reg[SW-1 -: 2]};
        trial = DW'({root_reg, 2'b01});
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_MUL: begin
                alu_a = AW'(acc_reg);
                alu_b = AW'(mc_reg);
            end
            S_COMB: begin
                alu_a   = AW'(p_reg);
                alu_b   = AW'(u_reg);
                alu_sub = (s1_reg != s2_reg);
            end
            S_COMB2: begin
                alu_a   = AW'(u_reg);
                alu_b   = AW'(p_reg);
                alu_sub = 1'b1;
            end
            S_GCD: begin
                alu_a   = AW'(u_reg);
                alu_b   = AW'(v_reg);
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = dtmp;
                alu_b   = AW'(u_reg);
                alu_sub = 1'b1;
            end
            S_SQRT: begin
                alu_a   = AW'(tr);
                alu_b   = AW'(trial);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        s1_next = s1_reg; s2_next = s2_reg; sd_next = sd_reg; nneg_next = nneg_reg;
        p_next = p_reg; u_next = u_reg; v_next = v_reg;
        mc_next = mc_reg; acc_next = acc_reg; mp_next = mp_reg;
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg; q_next = q_reg;
        k_next = k_reg; cnt_next = cnt_reg; slot_next = slot_reg; sel_next = sel_reg;
        inexact_next = inexact_reg; src_next = src_reg; root_next = root_reg;
        rn_next = rn_reg; st_next = st_reg;
        out_num_next = out_num_reg; out_den_next = out_den_reg; out_st_next = out_st_reg;

        acc_n  = mp_reg[0] ? alu_res[DW-1:0] : acc_reg;
        qbit   = !alu_borrow;
        qn     = {q_reg[DW-2:0], qbit};
        sq_ok  = !alu_borrow;
        rootn  = {root_reg[HW-2:0], sq_ok};
        sq_rem = sq_ok ? alu_res[DW-1:0] : tr;
        mag32  = 32'(num_reg[WIDTH-1:0]);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_operation;
                    an_next = an_mag; ad_next = ad_mag; bn_next = bn_mag; bd_next = bd_mag;
                    st_next = rau_pkg::ST_OK;
                    inexact_next = 1'b0;
                    num_next = DW'(an_mag);
                    den_next = DW'(ad_mag);
                    if (ad_mag == '0 || (!s_operation[2] && bd_mag == '0)
                        || (s_operation == rau_pkg::OP_DIV && bn_mag == '0)) begin
                        st_next    = rau_pkg::ST_ZDEN;
                        state_next = S_CHK;
                    end else if (!s_operation[2]) begin
                        s1_next = (s_operation == rau_pkg::OP_MUL) ? (an_neg ^ bn_neg)
                                                                   : (an_neg ^ bd_neg);
                        s2_next = bn_neg ^ ad_neg ^ (s_operation == rau_pkg::OP_SUB);
                        sd_next = (s_operation == rau_pkg::OP_DIV) ? (ad_neg ^ bn_neg)
                                                                   : (ad_neg ^ bd_neg);
                        slot_next  = 2'd0;
                        mc_next    = DW'(an_mag);
                        mp_next    = (s_operation == rau_pkg::OP_MUL) ? bn_mag : bd_mag;
                        acc_next   = '0;
                        cnt_next   = CW'(WIDTH);
                        state_next = S_MUL;
                    end else if (s_operation == rau_pkg::OP_SQRT) begin
                        nneg_next = 1'b0;
                        if (an_mag == '0) begin
                            state_next = S_GINIT;
                        end else if (an_neg != ad_neg) begin
                            st_next    = rau_pkg::ST_SQRT;
                            state_next = S_CHK;
                        end else begin
                            state_next = S_GINIT;
                        end
                    end else begin
                        nneg_next  = ((s_operation == rau_pkg::OP_NEG) ? !an_neg : an_neg)
                                     ^ ad_neg;
                        state_next = S_GINIT;
                    end
                end
            end
            S_MUL: begin
                acc_next = acc_n;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    unique case (slot_reg)
                        2'd0: p_next = acc_n;
                        2'd1: u_next = acc_n;
                        default: den_next = acc_n;
                    endcase
                    acc_next = '0;
                    cnt_next = CW'(WIDTH);
                    if (slot_reg == 2'd0) begin
                        slot_next = 2'd1;
                        mc_next   = DW'(bn_reg);
                        mp_next   = ad_reg;
                    end else if (slot_reg == 2'd1) begin
                        slot_next = 2'd2;
                        mc_next   = DW'(ad_reg);
                        mp_next   = (op_reg == rau_pkg::OP_DIV) ? bn_reg : bd_reg;
                    end else begin
                        state_next = S_COMB;
                    end
                end
            end
            S_COMB: begin
                state_next = S_GINIT;
                nneg_next  = s1_reg ^ sd_reg;
                if (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV) begin
                    num_next = p_reg;
                end else if (s1_reg == s2_reg || !alu_borrow) begin
                    num_next = alu_res[DW-1:0];
                end else begin
                    state_next = S_COMB2;
                end
            end
            S_COMB2: begin
                num_next   = alu_res[DW-1:0];
                nneg_next  = s2_reg ^ sd_reg;
                state_next = S_GINIT;
            end
            S_GINIT: begin
                if (num_reg == '0) begin
                    den_next   = DW'(1);
                    nneg_next  = 1'b0;
                    state_next = S_CHK;
                end else begin
                    u_next     = num_reg;
                    v_next     = den_reg;
                    k_next     = '0;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                priority if (alu_res[DW-1:0] == '0) begin
                    state_next = S_GSH;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (!alu_borrow) begin
                    u_next = alu_res[DW-1:0] >> 1;
                end else begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            S_GSH: begin
                if (k_reg == '0) begin
                    sel_next   = 1'b0;
                    rem_next   = '0;
                    q_next     = num_reg;
                    cnt_next   = CW'(DW);
                    state_next = S_DIV;
                end else begin
                    u_next = u_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end
            S_DIV: begin
                rem_next = alu_borrow ? dtmp[DW-1:0] : alu_res[DW-1:0];
                q_next   = qn;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if (!sel_reg) begin
                        num_next = qn;
                        sel_next = 1'b1;
                        rem_next = '0;
                        q_next   = den_reg;
                        cnt_next = CW'(DW);
                    end else begin
                        den_next = qn;
                        if (op_reg == rau_pkg::OP_SQRT) begin
                            sel_next   = 1'b0;
                            src_next   = SW'(num_reg);
                            rem_next   = '0;
                            root_next  = '0;
                            cnt_next   = CW'(HW);
                            state_next = S_SQRT;
                        end else begin
                            state_next = S_CHK;
                        end
                    end
                end
            end
            S_SQRT: begin
                rem_next  = sq_rem;
                root_next = rootn;
                src_next  = src_reg << 2;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    inexact_next = inexact_reg || (sq_rem != '0);
                    if (!sel_reg) begin
                        rn_next   = rootn;
                        sel_next  = 1'b1;
                        src_next  = SW'(den_reg);
                        rem_next  = '0;
                        root_next = '0;
                        cnt_next  = CW'(HW);
                    end else begin
                        if (inexact_reg || (sq_rem != '0)) begin
                            st_next = rau_pkg::ST_SQRT;
                        end
                        num_next   = DW'(rn_reg);
                        den_next   = DW'(rootn);
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (st_reg == rau_pkg::ST_OK
                    && (den_reg > LIM - 1'b1 || num_reg > (nneg_reg ? LIM : LIM - 1'b1))) begin
                    st_next = rau_pkg::ST_OVF;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_st_next  = st_reg;
                    if (st_reg == rau_pkg::ST_OK) begin
                        out_num_next = nneg_reg ? (32'd0 - mag32) : mag32;
                        out_den_next = rau_pkg::DEN_W'(den_reg[WIDTH-2:0]);
                    end else begin
                        out_num_next = '0;
                        out_den_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
        s1_reg <= s1_next; s2_reg <= s2_next; sd_reg <= sd_next; nneg_reg <= nneg_next;
        p_reg <= p_next; u_reg <= u_next; v_reg <= v_next;
        mc_reg <= mc_next; acc_reg <= acc_next; mp_reg <= mp_next;
        num_reg <= num_next; den_reg <= den_next; rem_reg <= rem_next; q_reg <= q_next;
        k_reg <= k_next; cnt_reg <= cnt_next; slot_reg <= slot_next; sel_reg <= sel_next;
        inexact_reg <= inexact_next; src_reg <= src_next; root_reg <= root_next;
        rn_reg <= rn_next; st_reg <= st_next;
        out_num_reg <= out_num_next; out_den_reg <= out_den_next; out_st_reg <= out_st_next;
    end

endmodule

// ===== sv/rau_alu.sv =====
`timescale 1ns / 1ps

module rau_alu #(
    parameter int AW = 65
) (
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    input  logic          sub,
    output logic [AW-1:0] res,
    output logic          borrow
);

    logic          carry;
    logic [AW-1:0] b_eff;

    assign b_eff          = sub ? ~b : b;
    assign {carry, res}   = {1'b0, a} + {1'b0, b_eff} + {{AW{1'b0}}, sub};
    assign borrow         = sub & ~carry;

endmodule

// ===== sv/rau_checker.sv =====
`timescale 1ns / 1ps

module rau_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [rau_pkg::OP_W-1:0]      s_operation,
    input logic [rau_pkg::FIELD_W-1:0]   s_a_num,
    input logic [rau_pkg::FIELD_W-1:0]   s_a_den,
    input logic [rau_pkg::FIELD_W-1:0]   s_b_num,
    input logic [rau_pkg::FIELD_W-1:0]   s_b_den,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rau_pkg::NUM_W-1:0]     m_res_num,
    input logic [rau_pkg::DEN_W-1:0]     m_res_den,
    input logic [rau_pkg::STATUS_W-1:0]  m_status
);

    // A stalled result must hold until its transfer completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_num) && $stable(m_res_den)
                                && $stable(m_status))
        else $error("result changed while stalled");

    // Every error status carries a zero fraction.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rau_pkg::ST_OK |-> m_res_num == '0 && m_res_den == '0)
        else $error("error result is not zero");

    // A good result always has a positive denominator.
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rau_pkg::ST_OK |-> m_res_den != '0)
        else $error("zero denominator with ok status");

    // The unit takes one operation at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// ===== sim/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;

    localparam int W = rau_pkg::WIDTH_DEF;
    localparam int N_RANDOM = 700;
    localparam longint CYCLE_LIMIT = 64'd4000000;
    localparam int HOLD_CYCLES = 4000;
    localparam logic [rau_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [rau_pkg::OP_W-1:0]    op;
        logic [rau_pkg::FIELD_W-1:0] an;
        logic [rau_pkg::FIELD_W-1:0] ad;
        logic [rau_pkg::FIELD_W-1:0] bn;
        logic [rau_pkg::FIELD_W-1:0] bd;
    } frac_op_t;

    typedef struct packed {
        logic [rau_pkg::NUM_W-1:0]    num;
        logic [rau_pkg::DEN_W-1:0]    den;
        logic [rau_pkg::STATUS_W-1:0] st;
    } frac_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [rau_pkg::OP_W-1:0] s_operation = '0;
    logic signed [rau_pkg::FIELD_W-1:0] s_a_num = '0;
    logic signed [rau_pkg::FIELD_W-1:0] s_a_den = '0;
    logic signed [rau_pkg::FIELD_W-1:0] s_b_num = '0;
    logic signed [rau_pkg::FIELD_W-1:0] s_b_den = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [rau_pkg::NUM_W-1:0] m_res_num;
    logic [rau_pkg::DEN_W-1:0] m_res_den;
    logic [rau_pkg::STATUS_W-1:0] m_status;

    frac_op_t  pending_ops[$];
    frac_res_t expected_fracs[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    bit        calm_mode = 1'b0;
    bit        hold_req = 1'b0;
    int        hold_count = 0;

    rational_arithmetic_unit #(.WIDTH(W)) dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= x) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function automatic void split_sm(logic [rau_pkg::FIELD_W-1:0] raw, output bit neg,
                                     output logic [63:0] mag);
        logic [63:0] full;
        logic [63:0] v;
        full = 64'd1 << W;
        v = {32'd0, raw} & (full - 1);
        neg = v[W-1];
        mag = neg ? full - v : v;
    endfunction

    function automatic frac_res_t error_frac(logic [rau_pkg::STATUS_W-1:0] st);
        frac_res_t r;
        r.num = '0;
        r.den = '0;
        r.st = st;
        return r;
    endfunction

    function automatic frac_res_t reduce_frac(bit nneg, logic [63:0] nmag, bit dneg,
                                              logic [63:0] dmag);
        frac_res_t r;
        logic [63:0] g;
        logic [63:0] lim;
        logic [63:0] sn;
        bit neg;
        lim = 64'd1 << (W - 1);
        if (dmag == 0) return error_frac(rau_pkg::ST_ZDEN);
        if (nmag == 0) begin
            r.num = '0;
            r.den = rau_pkg::DEN_W'(1);
            r.st = rau_pkg::ST_OK;
            return r;
        end
        g = gcd64(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        neg = nneg != dneg;
        if (dmag > lim - 1 || nmag > (neg ? lim : lim - 1))
            return error_frac(rau_pkg::ST_OVF);
        sn = neg ? 64'd0 - nmag : nmag;
        r.num = sn[rau_pkg::NUM_W-1:0];
        r.den = dmag[rau_pkg::DEN_W-1:0];
        r.st = rau_pkg::ST_OK;
        return r;
    endfunction

    function automatic frac_res_t compute_frac(frac_op_t t);
        bit an_s, ad_s, bn_s, bd_s, s1, s2, sn;
        logic [63:0] an_m, ad_m, bn_m, bd_m, m1, m2, mn, g, n, d, rn, rd;
        split_sm(t.an, an_s, an_m);
        split_sm(t.ad, ad_s, ad_m);
        split_sm(t.bn, bn_s, bn_m);
        split_sm(t.bd, bd_s, bd_m);
        case (t.op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (ad_m == 0 || bd_m == 0) return error_frac(rau_pkg::ST_ZDEN);
                s1 = an_s != bd_s;
                s2 = (bn_s != ad_s) != (t.op == rau_pkg::OP_SUB);
                m1 = an_m * bd_m;
                m2 = bn_m * ad_m;
                if (s1 == s2) begin
                    sn = s1;
                    mn = m1 + m2;
                end else if (m1 >= m2) begin
                    sn = s1;
                    mn = m1 - m2;
                end else begin
                    sn = s2;
                    mn = m2 - m1;
                end
                return reduce_frac(sn, mn, ad_s != bd_s, ad_m * bd_m);
            end
            rau_pkg::OP_MUL: begin
                if (ad_m == 0 || bd_m == 0) return error_frac(rau_pkg::ST_ZDEN);
                return reduce_frac(an_s != bn_s, an_m * bn_m, ad_s != bd_s, ad_m * bd_m);
            end
            rau_pkg::OP_DIV: begin
                if (ad_m == 0 || bd_m == 0 || bn_m == 0)
                    return error_frac(rau_pkg::ST_ZDEN);
                return reduce_frac(an_s != bd_s, an_m * bd_m, ad_s != bn_s, ad_m * bn_m);
            end
            rau_pkg::OP_NEG: return reduce_frac(!an_s, an_m, ad_s, ad_m);
            rau_pkg::OP_SQRT: begin
                if (ad_m == 0) return error_frac(rau_pkg::ST_ZDEN);
                if (an_m == 0) return reduce_frac(1'b0, 64'd0, 1'b0, 64'd1);
                if (an_s != ad_s) return error_frac(rau_pkg::ST_SQRT);
                g = gcd64(an_m, ad_m);
                n = an_m / g;
                d = ad_m / g;
                rn = isqrt64(n);
                rd = isqrt64(d);
                if (rn * rn != n || rd * rd != d) return error_frac(rau_pkg::ST_SQRT);
                return reduce_frac(1'b0, rn, 1'b0, rd);
            end
            default: return reduce_frac(an_s, an_m, ad_s, ad_m);
        endcase
    endfunction

    task automatic queue_op(logic [rau_pkg::OP_W-1:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        frac_op_t t;
        t.op = op;
        t.an = an;
        t.ad = ad;
        t.bn = bn;
        t.bd = bd;
        pending_ops.push_back(t);
    endtask

    function automatic logic [31:0] rand_field();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 40) - 20;
            2: v = $urandom_range(1, 300) * $urandom_range(1, 300);
            3: v = {1'($urandom_range(0, 1)), 31'd0} + $urandom_range(0, 3) - 1;
            4: v = $urandom_range(1, 65535);
            default: v = $urandom_range(0, 46340) * $urandom_range(0, 46340);
        endcase
        if (v != 0 && $urandom_range(0, 2) == 0) v = -v;
        return v;
    endfunction

    function automatic logic [rau_pkg::OP_W-1:0] rand_op();
        return rau_pkg::OP_W'($urandom_range(0, 7));
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout");
            $display("** rational_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    // Driver: accepted transfers are seen at the rising edge, updates at the falling edge.
    bit s_fire;
    always @(posedge aclk) s_fire <= aresetn && s_valid && s_ready;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire || !s_valid) begin
                if (pending_ops.size() > 0 && (calm_mode || $urandom_range(0, 99) >= 28)) begin
                    frac_op_t t;
                    t = pending_ops.pop_front();
                    expected_fracs.push_back(compute_frac(t));
                    s_valid <= 1'b1;
                    s_operation <= t.op;
                    s_a_num <= t.an;
                    s_a_den <= t.ad;
                    s_b_num <= t.bn;
                    s_b_den <= t.bd;
                end else begin
                    s_valid <= 1'b0;
                    if (s_fire) s_operation <= rau_pkg::OP_W'($urandom);
                end
            end
        end
    end

    // The long receiver stall is counted here.
    always @(negedge aclk) begin
        if (hold_req && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && hold_count < HOLD_CYCLES) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm_mode || $urandom_range(0, 99) >= 28;
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frac_res_t want;
            if (expected_fracs.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_status), 64'd0);
            end else begin
                want = expected_fracs.pop_front();
                if (m_res_num !== want.num) report_mismatch("res_num", m_res_num, want.num);
                if (m_res_den !== want.den) report_mismatch("res_den", m_res_den, want.den);
                if (m_status !== want.st) report_mismatch("status", m_status, want.st);
            end
        end
    end

    initial begin
        logic [rau_pkg::OP_W-1:0] op;
        logic [31:0] a;
        logic [31:0] b;
        queue_op(rau_pkg::OP_ADD, 1, 2, 1, 3);
        queue_op(rau_pkg::OP_SUB, 1, 2, 1, 2);
        queue_op(rau_pkg::OP_MUL, -6, 4, 10, -9);
        queue_op(rau_pkg::OP_DIV, 3, 7, -5, 2);
        queue_op(rau_pkg::OP_DIV, 3, 7, 0, 2);
        queue_op(rau_pkg::OP_ADD, 1, 0, 1, 3);
        queue_op(rau_pkg::OP_MUL, 1, 3, 1, 0);
        queue_op(rau_pkg::OP_NEG, 32'h8000_0000, 1, 0, 0);
        queue_op(rau_pkg::OP_NEG, 32'h7FFF_FFFF, -1, 0, 0);
        queue_op(rau_pkg::OP_SQRT, 9, 16, 0, 0);
        queue_op(rau_pkg::OP_SQRT, 18, 32, 0, 0);
        queue_op(rau_pkg::OP_SQRT, -4, 9, 0, 0);
        queue_op(rau_pkg::OP_SQRT, -4, -9, 0, 0);
        queue_op(rau_pkg::OP_SQRT, 2, 9, 0, 0);
        queue_op(rau_pkg::OP_SQRT, 0, 5, 0, 0);
        queue_op(rau_pkg::OP_NORM, 0, -7, 0, 0);
        queue_op(rau_pkg::OP_NORM, 6, -4, 0, 0);
        queue_op(rau_pkg::OP_NORM, 5, 32'h8000_0000, 0, 0);
        queue_op(OP_UNUSED, -10, 4, 1, 1);
        queue_op(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        queue_op(rau_pkg::OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        queue_op(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        queue_op(rau_pkg::OP_SQRT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_ops.size() == 0);
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) queue_op(rand_op(), rand_field(),
            rand_field(), rand_field(), rand_field());
        wait (pending_ops.size() == 0);
        calm_mode = 1'b1;
        for (int i = 0; i < 100; i++) queue_op(rand_op(), rand_field(),
            rand_field(), rand_field(), rand_field());
        wait (pending_ops.size() == 0);
        calm_mode = 1'b0;
        for (int i = 0; i < N_RANDOM - 100; i++) begin
            op = rand_op();
            if (op == rau_pkg::OP_SQRT && $urandom_range(0, 1) == 1) begin
                a = $urandom_range(0, 3000);
                b = $urandom_range(1, 3000);
                if ($urandom_range(0, 3) == 0) queue_op(op, -a * a, -b * b, $urandom, $urandom);
                else queue_op(op, a * a * $urandom_range(1, 5), b * b, $urandom, $urandom);
            end else begin
                queue_op(op, rand_field(), rand_field(), rand_field(), rand_field());
            end
        end
        wait (pending_ops.size() == 0 && expected_fracs.size() == 0);
        repeat (1000) @(posedge aclk);
        if (error_count == 0 && expected_fracs.size() == 0) begin
            $display("** rational_arithmetic_unit: PASSED **");
        end else begin
            $display("** rational_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule
